[rtl/core/gdfw_pkg.sv]
// ============================================================================
// gdfw_pkg
// Types and constants shared by the depth-first walk block and its parts.
// ============================================================================
package gdfw_pkg;

    localparam int VERT_W      = 5;   // width of a vertex number
    localparam int LINK_W      = 8;   // width of an edge slot link
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;
    localparam int CFG_W       = 6;
    localparam int CNT_W       = 7;   // holds a vertex count up to 64
    localparam int NRES_W      = 6;   // holds a result count up to 32

    localparam logic [LINK_W-1:0] EMPTY_LINK   = 8'hFF;
    localparam logic [NRES_W-1:0] RESULT_LIMIT = 6'd32;
    localparam logic [CFG_W-1:0]  VCNT_RESET   = 6'd32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD1,
        S_ADD2,
        S_TOP,
        S_CHK,
        S_EMIT
    } t_state;

    // One entry of the edge store.
    typedef struct packed {
        logic [VERT_W-1:0] tgt;
        logic [LINK_W-1:0] lnk;
    } t_edge_ent;

endpackage

[rtl/core/gdfw_edge_mem.sv]
// ============================================================================
// gdfw_edge_mem
// Edge store: one write port, one read port with registered read data.
// ============================================================================
module gdfw_edge_mem
    import gdfw_pkg::*;
#(
    parameter int EDGE_SLOTS = 128,
    parameter int AW         = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_edge_ent     i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_edge_ent     o_rdata
);

    t_edge_ent r_mem [EDGE_SLOTS];
    t_edge_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/graph_depth_first_walk.sv]
// ============================================================================
// graph_depth_first_walk
// Undirected graph in per-vertex adjacency lists with a depth-first walk.
// ============================================================================
// Sequence: an add passes S_ADD1, S_ADD2 and S_EMIT to its result item, a clear
// or a rejected request goes straight to S_EMIT. A search examines each edge
// entry in S_TOP and S_CHK, one at a time through the single read port of the
// edge store, reports each vertex through S_EMIT and pops the stack in S_TOP.
// The block takes one item at a time and stalls its input until the last
// result item is registered.
// Reset (synchronous, active low) empties every list, clears visited marks,
// the edge count and the stack, and sets the vertex count to 32.
// ============================================================================
module graph_depth_first_walk
    import gdfw_pkg::*;
#(
    parameter int MAX_NODES  = 32,
    parameter int EDGE_SLOTS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: vertex count.
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // Request channel.
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [VERT_W-1:0] i_first_vertex,
    input  logic [VERT_W-1:0] i_second_vertex,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VERT_W-1:0] o_visited_vertex,
    output logic              o_is_last,
    output logic [STAT_W-1:0] o_status
);

    // Index widths follow from the parameters.
    localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEPW = $clog2(MAX_NODES + 1);
    localparam int AW   = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_vcnt;
    logic [LINK_W-1:0] r_head [MAX_NODES];
    logic [MAX_NODES-1:0] r_seen;
    logic [LINK_W-1:0] r_used;
    // Stack of list cursors; only the cursor of each level is ever needed.
    logic [LINK_W-1:0] r_cur [MAX_NODES];
    logic [DEPW-1:0]   r_depth;
    logic [NRES_W-1:0] r_nres;
    logic [VERT_W-1:0] r_pend;
    logic [VERT_W-1:0] r_a;
    logic [VERT_W-1:0] r_b;

    // Result waiting to go into the output register.
    logic [VERT_W-1:0] r_e_vtx;
    logic              r_e_last;
    logic [STAT_W-1:0] r_e_st;

    logic              r_out_valid;
    logic [VERT_W-1:0] r_out_vtx;
    logic              r_out_last;
    logic [STAT_W-1:0] r_out_st;

    logic              accept;
    logic [CNT_W-1:0]  act_count;
    logic              a_ok;
    logic              b_ok;
    logic              full;

    logic [NW-1:0]     top_idx;
    logic [LINK_W-1:0] cur_top;
    logic              cur_ok;
    logic [VERT_W-1:0] head_sel;
    logic [LINK_W-1:0] head_rd;
    logic              out_free;
    logic              walk_done;
    logic              t_new;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_edge_ent         mem_wdata;
    t_edge_ent         mem_rdata;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // A count above the store size acts as the store size.
    assign act_count = ({1'b0, r_vcnt} > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                             : {1'b0, r_vcnt};
    assign a_ok = {2'b00, i_first_vertex}  < act_count;
    assign b_ok = {2'b00, i_second_vertex} < act_count;
    assign full = ({1'b0, r_used} + 9'd2) > 9'(EDGE_SLOTS);

    assign top_idx   = NW'(r_depth - DEPW'(1));
    assign cur_top   = r_cur[top_idx];
    assign cur_ok    = (cur_top != EMPTY_LINK) && (cur_top < r_used);
    assign walk_done = (r_depth == '0) || (r_nres >= RESULT_LIMIT);

    // A neighbor is taken when it is in range and not yet visited.
    assign t_new = ({2'b00, mem_rdata.tgt} < act_count) && !r_seen[NW'(mem_rdata.tgt)];

    assign out_free = !r_out_valid || !i_out_stall;

    // Single read port on the list heads; the state picks the vertex.
    always_comb begin
        unique case (r_state)
            S_IDLE:  head_sel = i_first_vertex;
            S_ADD1:  head_sel = r_a;
            S_ADD2:  head_sel = r_b;
            S_CHK:   head_sel = mem_rdata.tgt;
            default: head_sel = r_a;
        endcase
    end
    assign head_rd = r_head[NW'(head_sel)];

    // Edge store write side: each add writes two entries, in S_ADD1 and then S_ADD2.
    assign mem_we    = (r_state == S_ADD1) || (r_state == S_ADD2);
    assign mem_waddr = r_used[AW-1:0];
    always_comb begin
        mem_wdata.lnk = head_rd;
        mem_wdata.tgt = (r_state == S_ADD1) ? r_b : r_a;
    end

    gdfw_edge_mem #(
        .EDGE_SLOTS (EDGE_SLOTS),
        .AW         (AW)
    ) u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (cur_top[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_ADD:    n_state = (a_ok && b_ok && !full) ? S_ADD1 : S_EMIT;
                        REQ_SEARCH: n_state = a_ok ? S_TOP : S_EMIT;
                        REQ_CLEAR:  n_state = S_EMIT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD1: n_state = S_ADD2;
            S_ADD2: n_state = S_EMIT;
            S_TOP: begin
                if (walk_done) begin
                    n_state = S_EMIT;
                end else if (cur_ok) begin
                    n_state = S_CHK;
                end
            end
            S_CHK:  n_state = t_new ? S_EMIT : S_TOP;
            S_EMIT: begin
                if (out_free) begin
                    n_state = r_e_last ? S_IDLE : S_TOP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= VCNT_RESET;
        end else if (i_cfg_we) begin
            r_vcnt <= i_cfg_wdata;
        end
    end

    // Graph and walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_head[i] <= EMPTY_LINK;
            end
            r_seen  <= '0;
            r_used  <= '0;
            r_depth <= '0;
            r_nres  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == REQ_SEARCH) && a_ok) begin
                        // Marks are cleared at the start of every search and
                        // only the start vertex is marked.
                        r_seen   <= MAX_NODES'(1) << i_first_vertex;
                        r_cur[0] <= head_rd;
                        r_depth  <= DEPW'(1);
                        r_nres   <= NRES_W'(1);
                    end else if (accept && (i_req_type == REQ_CLEAR)) begin
                        for (int i = 0; i < MAX_NODES; i++) begin
                            r_head[i] <= EMPTY_LINK;
                        end
                        r_seen  <= '0;
                        r_used  <= '0;
                        r_depth <= '0;
                    end
                end
                S_ADD1: begin
                    r_head[NW'(r_a)] <= r_used;
                    r_used           <= r_used + LINK_W'(1);
                end
                S_ADD2: begin
                    r_head[NW'(r_b)] <= r_used;
                    r_used           <= r_used + LINK_W'(1);
                end
                S_TOP: begin
                    if (walk_done) begin
                        r_depth <= '0;
                    end else if (!cur_ok) begin
                        r_depth <= r_depth - DEPW'(1);
                    end
                end
                S_CHK: begin
                    r_cur[top_idx] <= mem_rdata.lnk;
                    if (t_new) begin
                        r_seen[NW'(mem_rdata.tgt)] <= 1'b1;
                        r_nres                     <= r_nres + NRES_W'(1);
                        // Past the stack depth the vertex is still reported.
                        if (r_depth < DEPW'(MAX_NODES)) begin
                            r_cur[NW'(r_depth)] <= head_rd;
                            r_depth             <= r_depth + DEPW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Request operands, pending vertex and the staged result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a      <= i_first_vertex;
            r_b      <= i_second_vertex;
            r_pend   <= i_first_vertex;
            r_e_vtx  <= '0;
            r_e_last <= 1'b1;
            if (i_req_type == REQ_ADD) begin
                r_e_st <= !(a_ok && b_ok) ? ST_RANGE : (full ? ST_FULL : ST_OK);
            end else if (i_req_type == REQ_SEARCH) begin
                r_e_st <= a_ok ? ST_OK : ST_RANGE;
            end else begin
                r_e_st <= ST_OK;
            end
        end else if ((r_state == S_TOP) && walk_done) begin
            // The vertex held back is the last one of the walk.
            r_e_vtx  <= r_pend;
            r_e_last <= 1'b1;
            r_e_st   <= ST_OK;
        end else if ((r_state == S_CHK) && t_new) begin
            // A new vertex proves the held one was not last.
            r_e_vtx  <= r_pend;
            r_e_last <= 1'b0;
            r_e_st   <= ST_OK;
            r_pend   <= mem_rdata.tgt;
        end
    end

    // Output register parts the sequencer from the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_vtx  <= r_e_vtx;
            r_out_last <= r_e_last;
            r_out_st   <= r_e_st;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_visited_vertex = r_out_vtx;
    assign o_is_last        = r_out_last;
    assign o_status         = r_out_st;

endmodule

[rtl/core/gdfw_checker.sv]
// ============================================================================
// gdfw_checker
// Port-level checks for the depth-first walk block, bound to the top level.
// ============================================================================
module gdfw_checker
    import gdfw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [REQ_W-1:0]  i_req_type,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [VERT_W-1:0] o_visited_vertex,
    input logic              o_is_last,
    input logic [STAT_W-1:0] o_status
);

    // A result held by the receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_visited_vertex) && $stable(o_is_last)
            && $stable(o_status))
        else $error("result changed while stalled");

    // Rejections are single results carrying vertex zero.
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_is_last && (o_visited_vertex == '0))
        else $error("malformed rejection result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK) || (o_status == ST_FULL)
                        || (o_status == ST_RANGE))
        else $error("unknown status code");

    // A real request keeps the block busy for at least the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && ((i_req_type == REQ_ADD)
            || (i_req_type == REQ_SEARCH) || (i_req_type == REQ_CLEAR)) |=> o_in_stall)
        else $error("request accepted without going busy");

endmodule

bind graph_depth_first_walk gdfw_checker u_gdfw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_req_type       (i_req_type),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_visited_vertex (o_visited_vertex),
    .o_is_last        (o_is_last),
    .o_status         (o_status)
);
